### design/dsa_pkg.sv
// Shared types and constants for the decimal scale alignment block.
package dsa_pkg;

    localparam int MAN_W       = 96;
    localparam int LOW_W       = 64;
    localparam int HIGH_W      = MAN_W - LOW_W;
    localparam int SCALE_W     = 5;
    localparam int CHUNK_W     = 16;
    localparam int CHUNKS      = MAN_W / CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(CHUNKS);
    localparam int REM_W       = 4;
    localparam int CUR_W       = REM_W + CHUNK_W;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = CUR_W + RECIP_W;
    // floor(2^24 / 10); quotient estimate is exact or one low
    localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(1677721);
    localparam logic [REM_W-1:0]   TEN       = REM_W'(10);

    typedef logic [MAN_W-1:0]   man_t;
    typedef logic [SCALE_W-1:0] scale_t;

    typedef struct packed {
        logic [LOW_W-1:0]  a_low;
        logic [HIGH_W-1:0] a_high;
        scale_t            a_scale;
        logic              a_sign;
        logic [LOW_W-1:0]  b_low;
        logic [HIGH_W-1:0] b_high;
        scale_t            b_scale;
        logic              b_sign;
    } dsa_in_t;

    typedef struct packed {
        logic [LOW_W-1:0]  out_a_low;
        logic [HIGH_W-1:0] out_a_high;
        scale_t            out_a_scale;
        logic              out_a_sign;
        logic [LOW_W-1:0]  out_b_low;
        logic [HIGH_W-1:0] out_b_high;
        scale_t            out_b_scale;
        logic              out_b_sign;
    } dsa_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_DONE
    } dsa_state_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } dsa_op_t;

    typedef struct packed {
        dsa_op_t          op;
        logic [REM_W-1:0] rem;
    } dsa_unit_ctrl_t;

    typedef struct packed {
        man_t             value;
        logic             ovf;
        logic [REM_W-1:0] rem;
    } dsa_unit_res_t;

endpackage

### design/dsa_in_if.sv
// Valid/ready channel carrying one operand pair.
interface dsa_in_if;
    import dsa_pkg::*;

    logic    valid;
    logic    ready;
    dsa_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/dsa_out_if.sv
// Valid/ready channel carrying one aligned operand pair.
interface dsa_out_if;
    import dsa_pkg::*;

    logic     valid;
    logic     ready;
    dsa_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/dsa_step_unit.sv
// Shared arithmetic unit: mantissa times ten, or one 16-bit digit of divide by ten.
module dsa_step_unit (
    input  dsa_pkg::man_t          operand,
    input  dsa_pkg::dsa_unit_ctrl_t ctrl,
    output dsa_pkg::dsa_unit_res_t  res
);
    import dsa_pkg::*;

    logic [MAN_W+3:0]   prod10;
    logic [CUR_W-1:0]   cur;
    logic [PROD_W-1:0]  est;
    logic [CHUNK_W-1:0] q0;
    logic [CUR_W-1:0]   q0_x10;
    logic [CUR_W-1:0]   r0;
    logic [CHUNK_W-1:0] q;
    logic [REM_W-1:0]   r;

    // x*10 = x*8 + x*2; the product needs four bits above the mantissa
    assign prod10 = {1'b0, operand, 3'b000} + {3'b000, operand, 1'b0};

    // Long division by ten, top chunk first; remainder carries between chunks
    assign cur    = {ctrl.rem, operand[MAN_W-1 -: CHUNK_W]};
    assign est    = PROD_W'(cur) * PROD_W'(RECIP_TEN);
    assign q0     = est[RECIP_SHIFT +: CHUNK_W];
    assign q0_x10 = {1'b0, q0, 3'b000} + {3'b000, q0, 1'b0};
    assign r0     = cur - q0_x10;

    always_comb
    begin
        if (r0 >= CUR_W'(TEN))
        begin
            q = q0 + CHUNK_W'(1);
            r = REM_W'(r0 - CUR_W'(TEN));
        end
        else
        begin
            q = q0;
            r = REM_W'(r0);
        end
    end

    always_comb
    begin
        unique case (ctrl.op)
            OP_MUL:
            begin
                res.value = prod10[MAN_W-1:0];
                res.ovf   = |prod10[MAN_W+3:MAN_W];
                res.rem   = '0;
            end
            OP_DIV:
            begin
                // rotate: consumed chunk leaves the top, quotient enters the bottom
                res.value = {operand[MAN_W-CHUNK_W-1:0], q};
                res.ovf   = 1'b0;
                res.rem   = r;
            end
            default:
            begin
                res.value = '0;
                res.ovf   = 1'b0;
                res.rem   = '0;
            end
        endcase
    end

endmodule

### design/decimal_scale_alignment_core.sv
// Decimal scale alignment: brings two 96-bit decimal operands to a common scale.
//
// Channels: operands (sink) takes a pair of decimals, each a 96-bit mantissa
// split into low/high words, a 5-bit scale and a sign. aligned (source) returns
// both mantissas at one common scale, signs unchanged. One result per item.
// An item is taken when valid and ready are both high at a rising clk edge.
//
// Steps: each scale step uses the shared step unit. A step multiplies the
// low-scale mantissa by ten; when that would overflow, the other mantissa is
// divided by ten instead, one 16-bit digit at a time over its six digits, and
// the block then tries the next step. There are M multiply steps and D divide
// steps, with M + D = scale difference, at most 31. operands.ready is high only
// while no item is in work, so the next item is taken only once the previous
// result has gone to the output register.
//
// The output register holds a finished result until aligned.ready; the next
// item may be taken meanwhile, and its result waits in the sequencer.
// Reset (rst_n low, asynchronous) returns to idle and drops any held result.
module decimal_scale_alignment_core (
    input  logic       clk,
    input  logic       rst_n,
    dsa_in_if.sink     operands,
    dsa_out_if.source  aligned
);
    import dsa_pkg::*;

    dsa_state_t                state_reg, state_next;
    logic [CHUNK_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic                      out_valid_reg, out_valid_next;
    man_t                      a_man_reg, a_man_next;
    man_t                      b_man_reg, b_man_next;
    scale_t                    a_scale_reg, a_scale_next;
    scale_t                    b_scale_reg, b_scale_next;
    logic                      a_sign_reg, a_sign_next;
    logic                      b_sign_reg, b_sign_next;
    dsa_out_t                  out_data_reg, out_data_next;

    logic                      lo_is_a;
    man_t                      unit_operand;
    dsa_unit_ctrl_t            unit_ctrl;
    dsa_unit_res_t             unit_res;

    assign lo_is_a = (a_scale_reg < b_scale_reg);

    always_comb
    begin
        unit_ctrl.rem = rem_reg;
        if (state_reg == ST_DIV)
        begin
            unit_ctrl.op = OP_DIV;
            unit_operand = lo_is_a ? b_man_reg : a_man_reg;
        end
        else
        begin
            unit_ctrl.op = OP_MUL;
            unit_operand = lo_is_a ? a_man_reg : b_man_reg;
        end
    end

    dsa_step_unit u_step (
        .operand (unit_operand),
        .ctrl    (unit_ctrl),
        .res     (unit_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        a_man_reg    <= a_man_next;
        b_man_reg    <= b_man_next;
        a_scale_reg  <= a_scale_next;
        b_scale_reg  <= b_scale_next;
        a_sign_reg   <= a_sign_next;
        b_sign_reg   <= b_sign_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        a_man_next     = a_man_reg;
        b_man_next     = b_man_reg;
        a_scale_next   = a_scale_reg;
        b_scale_next   = b_scale_reg;
        a_sign_next    = a_sign_reg;
        b_sign_next    = b_sign_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !aligned.ready;
        operands.ready = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                operands.ready = 1'b1;
                if (operands.valid)
                begin
                    a_man_next   = {operands.data.a_high, operands.data.a_low};
                    b_man_next   = {operands.data.b_high, operands.data.b_low};
                    a_scale_next = operands.data.a_scale;
                    b_scale_next = operands.data.b_scale;
                    a_sign_next  = operands.data.a_sign;
                    b_sign_next  = operands.data.b_sign;
                    state_next   = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (a_scale_reg == b_scale_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (!unit_res.ovf)
                begin
                    if (lo_is_a)
                    begin
                        a_man_next   = unit_res.value;
                        a_scale_next = a_scale_reg + SCALE_W'(1);
                    end
                    else
                    begin
                        b_man_next   = unit_res.value;
                        b_scale_next = b_scale_reg + SCALE_W'(1);
                    end
                end
                else
                begin
                    // keep the low-scale mantissa, shrink the other one instead
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = unit_res.rem;
                cnt_next = cnt_reg + CHUNK_CNT_W'(1);
                if (lo_is_a)
                begin
                    b_man_next = unit_res.value;
                end
                else
                begin
                    a_man_next = unit_res.value;
                end
                if (cnt_reg == CHUNK_CNT_W'(CHUNKS - 1))
                begin
                    if (lo_is_a)
                    begin
                        b_scale_next = b_scale_reg - SCALE_W'(1);
                    end
                    else
                    begin
                        a_scale_next = a_scale_reg - SCALE_W'(1);
                    end
                    state_next = ST_STEP;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || aligned.ready)
                begin
                    out_data_next.out_a_low   = a_man_reg[LOW_W-1:0];
                    out_data_next.out_a_high  = a_man_reg[MAN_W-1:LOW_W];
                    out_data_next.out_a_scale = a_scale_reg;
                    out_data_next.out_a_sign  = a_sign_reg;
                    out_data_next.out_b_low   = b_man_reg[LOW_W-1:0];
                    out_data_next.out_b_high  = b_man_reg[MAN_W-1:LOW_W];
                    out_data_next.out_b_scale = b_scale_reg;
                    out_data_next.out_b_sign  = b_sign_reg;
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign aligned.valid = out_valid_reg;
    assign aligned.data  = out_data_reg;

endmodule

### design/dsa_checker.sv
// Port-level checks for the decimal scale alignment block, with its bind.
module dsa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input dsa_pkg::dsa_out_t out_data
);
    import dsa_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("aligned result changed while stalled");

    // Both operands leave at one common scale.
    a_common_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.out_a_scale == out_data.out_b_scale)
        else $error("aligned scales differ");

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted item");

    // A new result is only produced while the input side is busy.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an item in work");

endmodule

bind decimal_scale_alignment_core dsa_checker u_dsa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (aligned.valid),
    .out_ready (aligned.ready),
    .out_data  (aligned.data)
);
